// ===== src/fca_pkg.sv =====
// Package for the float calculator ALU: opcodes, status codes, float constants,
// the shared unit's operation type and request struct, and iteration limits.
// No dependencies.
package fca_pkg;

	localparam int SqrtIterations = 20;
	localparam longint MaxExpMagnitude = 65535;
	localparam int IterW = $clog2(SqrtIterations + 1);
	localparam int MagW = $clog2(MaxExpMagnitude + 1);

	localparam logic [15:0] ACT_ADD = 16'd0;
	localparam logic [15:0] ACT_SUB = 16'd1;
	localparam logic [15:0] ACT_MUL = 16'd2;
	localparam logic [15:0] ACT_DIV = 16'd3;
	localparam logic [15:0] ACT_SQRT = 16'd4;
	localparam logic [15:0] ACT_RECIP = 16'd5;
	localparam logic [15:0] ACT_POW = 16'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [31:0] FP_ZERO = 32'h0000_0000;
	localparam logic [31:0] FP_ONE = 32'h3F80_0000;
	localparam logic [31:0] FP_HALF = 32'h3F00_0000;
	localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] FP_QUIET = 32'h0040_0000;

	typedef enum logic [1:0] {
		FOP_ADD,
		FOP_SUB,
		FOP_MUL,
		FOP_DIV
	} fop_t;

	typedef struct packed {
		logic go;
		fop_t op;
	} freq_t;

endpackage

// ===== src/fca_fpu.sv =====
// Shared binary32 add/sub/mul/div unit: one operation per request, iterated
// over cycles (bit-serial align, normalize and restoring divide), RNE rounding.
// Depends on fca_pkg.
module fca_fpu (
	input  logic           clk,
	input  logic           arst_n,
	input  fca_pkg::freq_t req,
	input  logic [31:0]    x,
	input  logic [31:0]    y,
	output logic           done,
	output logic [31:0]    res
);

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_ALIGN = 5'b00010,
		F_PREN  = 5'b00100,
		F_DIV   = 5'b01000,
		F_NORM  = 5'b10000
	} fstate_t;

	fstate_t            state_q;
	logic               sign_q;
	logic               sub_q;
	logic signed [11:0] exp_q;
	logic signed [11:0] expb_q;
	logic [49:0]        man_q;
	logic [49:0]        mb_q;
	logic [5:0]         cnt_q;
	logic [24:0]        rem_q;
	logic [26:0]        quo_q;
	logic               done_q;
	logic [31:0]        res_q;

	// operand fields
	logic       xs, ys, ysa;
	logic [7:0] xme, yme;
	logic [23:0] xm, ym;
	logic       x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;

	assign xs = x[31];
	assign ys = y[31];
	assign ysa = ys ^ (req.op == fca_pkg::FOP_SUB);
	assign xme = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
	assign yme = (y[30:23] == 8'h00) ? 8'd1 : y[30:23];
	assign xm = {x[30:23] != 8'h00, x[22:0]};
	assign ym = {y[30:23] != 8'h00, y[22:0]};
	assign x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	assign y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
	assign x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
	assign y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
	assign x_zero = (x[30:0] == 31'd0);
	assign y_zero = (y[30:0] == 31'd0);

	// special operands settle at once
	logic        spec;
	logic [31:0] spec_res;
	always_comb begin
		spec = 1'b1;
		spec_res = fca_pkg::FP_ZERO;
		unique case (req.op)
			fca_pkg::FOP_ADD, fca_pkg::FOP_SUB: begin
				priority if (x_nan) spec_res = x | fca_pkg::FP_QUIET;
				else if (y_nan) spec_res = y | fca_pkg::FP_QUIET;
				else if (x_inf && y_inf) spec_res = (xs == ysa) ? x : fca_pkg::FP_DEFAULT_NAN;
				else if (x_inf) spec_res = x;
				else if (y_inf) spec_res = {ysa, 8'hFF, 23'd0};
				else spec = 1'b0;
			end
			fca_pkg::FOP_MUL: begin
				priority if (x_nan) spec_res = x | fca_pkg::FP_QUIET;
				else if (y_nan) spec_res = y | fca_pkg::FP_QUIET;
				else if ((x_inf && y_zero) || (x_zero && y_inf)) spec_res = fca_pkg::FP_DEFAULT_NAN;
				else if (x_inf || y_inf) spec_res = {xs ^ ys, 8'hFF, 23'd0};
				else spec = 1'b0;
			end
			fca_pkg::FOP_DIV: begin
				priority if (y_zero) begin
					priority if (x_nan) spec_res = x | fca_pkg::FP_QUIET;
					else if (x_zero) spec_res = fca_pkg::FP_DEFAULT_NAN;
					else spec_res = {xs ^ ys, 8'hFF, 23'd0};
				end
				else if (x_nan) spec_res = x | fca_pkg::FP_QUIET;
				else if (y_nan) spec_res = y | fca_pkg::FP_QUIET;
				else if (x_inf && y_inf) spec_res = fca_pkg::FP_DEFAULT_NAN;
				else if (x_inf) spec_res = {xs ^ ys, 8'hFF, 23'd0};
				else if (y_inf || x_zero) spec_res = {xs ^ ys, 31'd0};
				else spec = 1'b0;
			end
			default: spec = 1'b0;
		endcase
	end

	// add setup: order by magnitude
	logic       x_big;
	logic [7:0] ed;
	assign x_big = {xme, xm} >= {yme, ym};
	assign ed = x_big ? (xme - yme) : (yme - xme);

	logic [47:0] prod;
	assign prod = 48'(xm) * 48'(ym);

	function automatic logic [49:0] shr1(input logic [49:0] v);
		shr1 = {1'b0, v[49:2], v[1] | v[0]};
	endfunction

	// align step result
	logic [49:0] sum;
	assign sum = sub_q ? (man_q - mb_q) : (man_q + mb_q);

	// divide step
	logic        ge;
	logic [24:0] rdiff;
	assign ge = rem_q >= {1'b0, mb_q[23:0]};
	assign rdiff = ge ? (rem_q - {1'b0, mb_q[23:0]}) : rem_q;

	// round to nearest even
	logic        up, hid;
	logic [24:0] rsum;
	logic [22:0] frac;
	logic signed [11:0] e_fin;
	logic [31:0] rounded;
	always_comb begin
		up = man_q[24] & ((|man_q[23:0]) | man_q[25]);
		rsum = {1'b0, man_q[48:25]} + 25'(up);
		if (rsum[24]) begin
			e_fin = exp_q + 12'sd1;
			frac = 23'd0;
			hid = 1'b1;
		end else begin
			e_fin = exp_q;
			frac = rsum[22:0];
			hid = rsum[23];
		end
		if (e_fin >= 12'sd255) rounded = {sign_q, 8'hFF, 23'd0};
		else rounded = {sign_q, hid ? e_fin[7:0] : 8'h00, frac};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q <= 1'b0;
			res_q <= '0;
			sign_q <= 1'b0;
			sub_q <= 1'b0;
			exp_q <= '0;
			expb_q <= '0;
			man_q <= '0;
			mb_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.go) begin
						if (spec) begin
							res_q <= spec_res;
							done_q <= 1'b1;
						end else begin
							unique case (req.op)
								fca_pkg::FOP_ADD, fca_pkg::FOP_SUB: begin
									man_q <= {1'b0, x_big ? xm : ym, 25'd0};
									mb_q <= {1'b0, x_big ? ym : xm, 25'd0};
									cnt_q <= (ed > 8'd50) ? 6'd50 : ed[5:0];
									exp_q <= $signed({4'b0, x_big ? xme : yme});
									sign_q <= x_big ? xs : ysa;
									sub_q <= xs ^ ysa;
									state_q <= F_ALIGN;
								end
								fca_pkg::FOP_MUL: begin
									man_q <= {prod, 2'b00};
									exp_q <= $signed({4'b0, xme}) + $signed({4'b0, yme}) - 12'sd127;
									sign_q <= xs ^ ys;
									state_q <= F_NORM;
								end
								default: begin
									man_q <= {26'd0, xm};
									mb_q <= {26'd0, ym};
									exp_q <= $signed({4'b0, xme});
									expb_q <= $signed({4'b0, yme});
									sign_q <= xs ^ ys;
									state_q <= F_PREN;
								end
							endcase
						end
					end
				end
				F_ALIGN: begin
					if (cnt_q != 6'd0) begin
						mb_q <= shr1(mb_q);
						cnt_q <= cnt_q - 6'd1;
					end else begin
						man_q <= sum;
						if (sub_q && sum == 50'd0) sign_q <= 1'b0;
						state_q <= F_NORM;
					end
				end
				F_PREN: begin
					if (man_q[23] && mb_q[23]) begin
						exp_q <= exp_q - expb_q + 12'sd127;
						rem_q <= {1'b0, man_q[23:0]};
						quo_q <= '0;
						cnt_q <= 6'd27;
						state_q <= F_DIV;
					end else begin
						if (!man_q[23]) begin
							man_q <= man_q << 1;
							exp_q <= exp_q - 12'sd1;
						end
						if (!mb_q[23]) begin
							mb_q <= mb_q << 1;
							expb_q <= expb_q - 12'sd1;
						end
					end
				end
				F_DIV: begin
					quo_q <= {quo_q[25:0], ge};
					rem_q <= {rdiff[23:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						man_q <= {1'b0, quo_q[25:0], ge, rdiff != 25'd0, 21'd0};
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (man_q[49] || exp_q < 12'sd1) begin
						if (exp_q < 12'sd1 && man_q[49:1] == 49'd0) begin
							exp_q <= 12'sd1;
						end else begin
							man_q <= shr1(man_q);
							exp_q <= exp_q + 12'sd1;
						end
					end else if (!man_q[48] && exp_q > 12'sd1 && man_q != 50'd0) begin
						man_q <= man_q << 1;
						exp_q <= exp_q - 12'sd1;
					end else begin
						res_q <= rounded;
						done_q <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== src/float_calculator_alu.sv =====
// Top level of the float calculator ALU: command decode and the sequencer for
// sqrt (Newton) and integer power around one shared fca_fpu.
// Depends on fca_pkg and fca_fpu.
//
// Usage:
//   Command channel: drive action, operand_a and operand_b and raise start;
//   the word is taken at the rising edge where start is high and busy is low.
//   busy stays high until the result is out; further starts are ignored.
//   Result channel: done is high for exactly one cycle with result_bits and
//   status valid; the receiver must take the word then, nothing holds it.
// Work per operation, all through the one shared add/mul/div unit:
//   special operands (NaN, inf, zero cases) finish without iterating;
//   multiply normalizes its product; add/sub aligns, then normalizes (one bit
//   per cycle of alignment, then of normalization); divide and reciprocal
//   normalize the operands, produce 27 quotient bits, then denormalize
//   tiny quotients.
//   Sqrt runs SqrtIterations rounds of divide, add and multiply; power runs
//   one multiply per unit of |n| (stopping early on a fixed point) plus one
//   divide for a negative n.
//   Unknown opcodes, sqrt of a non-positive value and power with n = 0
//   answer in the cycle after the start.
// Reset: arst_n clears the sequencer and the shared unit; busy and done go low.
module float_calculator_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] action,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        done,
	output logic [31:0] result_bits,
	output logic [1:0]  status
);

	typedef enum logic [2:0] {
		T_IDLE  = 3'b001,
		T_ISSUE = 3'b010,
		T_WAIT  = 3'b100
	} tstate_t;

	typedef enum logic [2:0] {
		K_ADD, K_SUB, K_MUL, K_DIV, K_SQRT, K_RECIP, K_POW
	} kind_t;

	typedef enum logic [1:0] {
		PH_DIV, PH_ADD, PH_MUL
	} phase_t;

	tstate_t                     state_q;
	kind_t                       kind_q;
	phase_t                      phase_q;
	logic [31:0]                 a_q, b_q, g_q, t_q;
	logic [fca_pkg::IterW-1:0]   iter_q;
	logic [fca_pkg::MagW-1:0]    cnt_q;
	logic                        neg_q, sat_q;
	logic                        done_q;
	logic [31:0]                 result_q;
	logic [1:0]                  status_q;

	fca_pkg::freq_t freq;
	logic [31:0]    fx, fy, fres;
	logic           fdone;

	// Truncate operand_b toward zero for power; saturate the magnitude.
	logic [7:0]  be;
	logic [31:0] bmant, tmag32, tmag_raw;
	logic        tneg, tsat;
	assign be = operand_b[30:23];
	assign bmant = {8'd0, 1'b1, operand_b[22:0]};
	always_comb begin
		tneg = operand_b[31];
		tsat = 1'b0;
		tmag_raw = 32'd0;
		priority if (be == 8'hFF) begin
			tneg = operand_b[31] & (operand_b[22:0] == 23'd0);
			tsat = 1'b1;
			tmag_raw = 32'(fca_pkg::MaxExpMagnitude);
		end else if (be < 8'd127) begin
			tmag_raw = 32'd0;
		end else if (be >= 8'd158) begin
			tsat = 1'b1;
			tmag_raw = 32'(fca_pkg::MaxExpMagnitude);
		end else if (be >= 8'd150) begin
			tmag_raw = bmant << (be - 8'd150);
		end else begin
			tmag_raw = bmant >> (8'd150 - be);
		end
		tmag32 = tmag_raw;
		if (tmag_raw > 32'(fca_pkg::MaxExpMagnitude)) begin
			tsat = 1'b1;
			tmag32 = 32'(fca_pkg::MaxExpMagnitude);
		end
	end

	// sqrt of zero, negatives and -inf gives +0; NaN goes through the loop
	logic a_nonpos;
	assign a_nonpos = !((operand_a[30:23] == 8'hFF) && (operand_a[22:0] != 23'd0)) &&
		(operand_a[31] || operand_a[30:0] == 31'd0);

	// Route the current step to the shared unit.
	always_comb begin
		freq.go = (state_q == T_ISSUE);
		freq.op = fca_pkg::FOP_ADD;
		fx = a_q;
		fy = b_q;
		unique case (kind_q)
			K_ADD: freq.op = fca_pkg::FOP_ADD;
			K_SUB: freq.op = fca_pkg::FOP_SUB;
			K_MUL: freq.op = fca_pkg::FOP_MUL;
			K_DIV: freq.op = fca_pkg::FOP_DIV;
			K_RECIP: begin
				freq.op = fca_pkg::FOP_DIV;
				fx = fca_pkg::FP_ONE;
				fy = a_q;
			end
			K_SQRT: begin
				unique case (phase_q)
					PH_DIV: begin
						freq.op = fca_pkg::FOP_DIV;
						fx = a_q;
						fy = g_q;
					end
					PH_ADD: begin
						freq.op = fca_pkg::FOP_ADD;
						fx = g_q;
						fy = t_q;
					end
					default: begin
						freq.op = fca_pkg::FOP_MUL;
						fx = fca_pkg::FP_HALF;
						fy = t_q;
					end
				endcase
			end
			K_POW: begin
				if (phase_q == PH_DIV) begin
					freq.op = fca_pkg::FOP_DIV;
					fx = fca_pkg::FP_ONE;
					fy = g_q;
				end else begin
					freq.op = fca_pkg::FOP_MUL;
					fx = g_q;
					fy = a_q;
				end
			end
			default: freq.op = fca_pkg::FOP_ADD;
		endcase
	end

	fca_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (freq),
		.x      (fx),
		.y      (fy),
		.done   (fdone),
		.res    (fres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			kind_q <= K_ADD;
			phase_q <= PH_DIV;
			a_q <= '0;
			b_q <= '0;
			g_q <= '0;
			t_q <= '0;
			iter_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			sat_q <= 1'b0;
			done_q <= 1'b0;
			result_q <= '0;
			status_q <= fca_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						// latch the command word
						a_q <= operand_a;
						b_q <= operand_b;
						sat_q <= 1'b0;
						phase_q <= PH_DIV;
						iter_q <= '0;
						unique case (action)
							fca_pkg::ACT_ADD: begin
								kind_q <= K_ADD;
								state_q <= T_ISSUE;
							end
							fca_pkg::ACT_SUB: begin
								kind_q <= K_SUB;
								state_q <= T_ISSUE;
							end
							fca_pkg::ACT_MUL: begin
								kind_q <= K_MUL;
								state_q <= T_ISSUE;
							end
							fca_pkg::ACT_DIV: begin
								kind_q <= K_DIV;
								state_q <= T_ISSUE;
							end
							fca_pkg::ACT_RECIP: begin
								kind_q <= K_RECIP;
								state_q <= T_ISSUE;
							end
							fca_pkg::ACT_SQRT: begin
								kind_q <= K_SQRT;
								g_q <= operand_a;
								if (a_nonpos) begin
									// answer +0 without iterating
									done_q <= 1'b1;
									result_q <= fca_pkg::FP_ZERO;
									status_q <= fca_pkg::ST_OK;
								end else begin
									state_q <= T_ISSUE;
								end
							end
							fca_pkg::ACT_POW: begin
								kind_q <= K_POW;
								g_q <= fca_pkg::FP_ONE;
								neg_q <= tneg;
								sat_q <= tsat;
								cnt_q <= fca_pkg::MagW'(tmag32);
								phase_q <= PH_MUL;
								if (tmag32 == 32'd0) begin
									// A^0 and its reciprocal are both 1.0
									done_q <= 1'b1;
									result_q <= fca_pkg::FP_ONE;
									status_q <= fca_pkg::ST_OK;
								end else begin
									state_q <= T_ISSUE;
								end
							end
							default: begin
								done_q <= 1'b1;
								result_q <= fca_pkg::FP_ZERO;
								status_q <= fca_pkg::ST_UNKNOWN;
							end
						endcase
					end
				end
				T_ISSUE: state_q <= T_WAIT;
				T_WAIT: begin
					if (fdone) begin
						state_q <= T_ISSUE;
						unique case (kind_q)
							K_SQRT: begin
								unique case (phase_q)
									PH_DIV: begin
										t_q <= fres;
										phase_q <= PH_ADD;
									end
									PH_ADD: begin
										t_q <= fres;
										phase_q <= PH_MUL;
									end
									default: begin
										// advance the guess; stop after the last round
										g_q <= fres;
										phase_q <= PH_DIV;
										iter_q <= iter_q + 1'b1;
										if (iter_q == fca_pkg::IterW'(fca_pkg::SqrtIterations - 1)) begin
											state_q <= T_IDLE;
											done_q <= 1'b1;
											result_q <= fres;
											status_q <= fca_pkg::ST_OK;
										end
									end
								endcase
							end
							K_POW: begin
								if (phase_q == PH_DIV) begin
									state_q <= T_IDLE;
									done_q <= 1'b1;
									result_q <= fres;
									status_q <= sat_q ? fca_pkg::ST_SAT : fca_pkg::ST_OK;
								end else begin
									g_q <= fres;
									cnt_q <= cnt_q - 1'b1;
									// drop the remaining multiplies at a fixed point
									if (fres == g_q || cnt_q == fca_pkg::MagW'(1)) begin
										if (neg_q) begin
											phase_q <= PH_DIV;
										end else begin
											state_q <= T_IDLE;
											done_q <= 1'b1;
											result_q <= fres;
											status_q <= sat_q ? fca_pkg::ST_SAT : fca_pkg::ST_OK;
										end
									end
								end
							end
							default: begin
								state_q <= T_IDLE;
								done_q <= 1'b1;
								result_q <= fres;
								status_q <= fca_pkg::ST_OK;
							end
						endcase
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign busy = (state_q != T_IDLE);
	assign done = done_q;
	assign result_bits = result_q;
	assign status = status_q;

endmodule

// ===== src/fca_checker.sv =====
// Port-level checks for float_calculator_alu, attached by bind.
// Depends on fca_pkg.
module fca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] result_bits,
	input logic [1:0]  status
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word while busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("command word dropped");

	a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy fell without a result word");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == fca_pkg::ST_OK || status == fca_pkg::ST_UNKNOWN ||
			status == fca_pkg::ST_SAT)) else $error("bad status code");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == fca_pkg::ST_UNKNOWN |-> result_bits == 32'd0)
		else $error("unknown opcode result not +0.0");

endmodule

bind float_calculator_alu fca_checker u_fca_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.result_bits (result_bits),
	.status      (status)
);

// ===== dv/float_calculator_alu_checker.sv =====
// Checker for the float calculator ALU: watches the command and result channels,
// predicts each result word in binary32 and compares it field by field.
// Depends on fca_pkg.
module float_calculator_alu_checker
	import fca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] action,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic        done,
	input  logic [31:0] result_bits,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] bits;
		logic [1:0]  code;
	} answer_t;

	answer_t expected_answers[$];

	function automatic logic is_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic logic is_inf(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] == 0;
	endfunction

	function automatic logic is_zero(logic [31:0] x);
		return x[30:0] == 0;
	endfunction

	// Exact binary32 -> binary64 widening, subnormals normalized; a NaN widens to inf.
	function automatic real widen_to_real(logic [31:0] x);
		logic [63:0] mant;
		int p;
		if (x[30:23] == 8'hFF)
			return $bitstoreal({x[31], 11'h7FF, 52'h0});
		if (x[30:0] == 0)
			return $bitstoreal({x[31], 63'h0});
		if (x[30:23] == 0) begin
			p = 0;
			for (int i = 0; i < 23; i++)
				if (x[i])
					p = i;
			mant = (64'(x[22:0]) << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF;
			return $bitstoreal({x[31], 11'(p - 149 + 1023), mant[51:0]});
		end
		return $bitstoreal({x[31], 11'(int'(x[30:23]) - 127 + 1023), x[22:0], 29'h0});
	endfunction

	// Round a binary64 value to binary32, nearest even, with subnormals.
	function automatic logic [31:0] round_to_single(real r);
		logic [63:0] d;
		logic [63:0] sig, kept, rem, half;
		int ex, shift;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF)
			return d[51:0] != 0 ? FP_DEFAULT_NAN : {d[63], 8'hFF, 23'h0};
		if (d[62:52] == 0)
			return {d[63], 31'h0};
		ex = int'(d[62:52]) - 1023;
		if (ex > 127)
			return {d[63], 8'hFF, 23'h0};
		sig = {11'h0, 1'b1, d[51:0]};
		shift = (ex >= -126) ? 29 : 29 + (-126 - ex);
		if (shift > 63)
			shift = 63;
		kept = sig >> shift;
		rem = sig & ((64'd1 << shift) - 1);
		half = 64'd1 << (shift - 1);
		if (rem > half || (rem == half && kept[0]))
			kept = kept + 1;
		if (ex >= -126) begin
			if (kept[24]) begin
				kept = kept >> 1;
				ex++;
			end
			if (ex > 127)
				return {d[63], 8'hFF, 23'h0};
			return {d[63], 8'(ex + 127), kept[22:0]};
		end
		return {d[63], 31'(kept)};
	endfunction

	// NaN operands propagate quieted, the first one winning.
	function automatic logic [31:0] single_add(logic [31:0] x, logic [31:0] y);
		if (is_nan(x)) return x | FP_QUIET;
		if (is_nan(y)) return y | FP_QUIET;
		if (is_inf(x) && is_inf(y) && x[31] != y[31]) return FP_DEFAULT_NAN;
		return round_to_single(widen_to_real(x) + widen_to_real(y));
	endfunction

	function automatic logic [31:0] single_sub(logic [31:0] x, logic [31:0] y);
		if (is_nan(x)) return x | FP_QUIET;
		if (is_nan(y)) return y | FP_QUIET;
		return single_add(x, {~y[31], y[30:0]});
	endfunction

	function automatic logic [31:0] single_mul(logic [31:0] x, logic [31:0] y);
		if (is_nan(x)) return x | FP_QUIET;
		if (is_nan(y)) return y | FP_QUIET;
		if ((is_zero(x) && is_inf(y)) || (is_inf(x) && is_zero(y))) return FP_DEFAULT_NAN;
		return round_to_single(widen_to_real(x) * widen_to_real(y));
	endfunction

	// Division with the zero-divisor rules applied before any arithmetic.
	function automatic logic [31:0] single_div(logic [31:0] x, logic [31:0] y);
		if (is_zero(y)) begin
			if (is_nan(x)) return x | FP_QUIET;
			if (is_zero(x)) return FP_DEFAULT_NAN;
			return {x[31] ^ y[31], 8'hFF, 23'h0};
		end
		if (is_nan(x)) return x | FP_QUIET;
		if (is_nan(y)) return y | FP_QUIET;
		if (is_inf(x) && is_inf(y)) return FP_DEFAULT_NAN;
		return round_to_single(widen_to_real(x) / widen_to_real(y));
	endfunction

	function automatic logic [31:0] newton_root(logic [31:0] v);
		logic [31:0] g;
		if (!is_nan(v) && (v[31] || is_zero(v)))
			return FP_ZERO;
		g = v;
		for (int i = 0; i < SqrtIterations; i++)
			g = single_mul(FP_HALF, single_add(g, single_div(v, g)));
		return g;
	endfunction

	// Power: truncate B to an integer, saturate, multiply up, stop at a fixed point.
	function automatic answer_t integer_power(logic [31:0] a, logic [31:0] b);
		answer_t ans;
		logic [31:0] prod, next;
		longint mag;
		logic neg, sat;
		int ef;
		longint mant;
		neg = b[31];
		sat = 1'b0;
		ef = int'(b[30:23]);
		mant = longint'({1'b1, b[22:0]});
		if (ef == 255) begin
			if (b[22:0] != 0)
				neg = 1'b0;
			sat = 1'b1;
			mag = MaxExpMagnitude;
		end else if (ef < 127)
			mag = 0;
		else if (ef >= 127 + 31) begin
			sat = 1'b1;
			mag = MaxExpMagnitude;
		end else begin
			mag = (ef >= 150) ? (mant << (ef - 150)) : (mant >> (150 - ef));
			if (mag > MaxExpMagnitude) begin
				sat = 1'b1;
				mag = MaxExpMagnitude;
			end
		end
		prod = FP_ONE;
		for (longint k = 0; k < mag; k++) begin
			next = single_mul(prod, a);
			if (next == prod)
				break;
			prod = next;
		end
		ans.bits = neg ? single_div(FP_ONE, prod) : prod;
		ans.code = sat ? ST_SAT : ST_OK;
		return ans;
	endfunction

	function automatic answer_t compute_word(logic [15:0] act, logic [31:0] a, logic [31:0] b);
		answer_t ans;
		ans.code = ST_OK;
		case (act)
			ACT_ADD:   ans.bits = single_add(a, b);
			ACT_SUB:   ans.bits = single_sub(a, b);
			ACT_MUL:   ans.bits = single_mul(a, b);
			ACT_DIV:   ans.bits = single_div(a, b);
			ACT_SQRT:  ans.bits = newton_root(a);
			ACT_RECIP: ans.bits = single_div(FP_ONE, a);
			ACT_POW:   ans = integer_power(a, b);
			default: begin
				ans.bits = FP_ZERO;
				ans.code = ST_UNKNOWN;
			end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			expected_answers.delete();
		end else begin
			if (start && !busy)
				expected_answers.push_back(compute_word(action, operand_a, operand_b));
			if (done) begin
				if (expected_answers.size() == 0) begin
					$error("result word with nothing expected: bits %h status %0d",
						result_bits, status);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_answers.pop_front();
					if (result_bits !== want.bits || status !== want.code) begin
						if (result_bits !== want.bits)
							$error("result_bits: expected %h, got %h", want.bits, result_bits);
						if (status !== want.code)
							$error("status: expected %0d, got %0d", want.code, status);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_answers.size();
		end
	end

endmodule

// ===== dv/float_calculator_alu_tb.sv =====
// Testbench top for the float calculator ALU: clock, reset and command stimulus,
// plus the verdict. Depends on fca_pkg, float_calculator_alu and its checker.
module float_calculator_alu_tb;
	import fca_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] action = ACT_ADD;
	logic [31:0] operand_a = FP_ZERO;
	logic [31:0] operand_b = FP_ZERO;
	logic        done;
	logic [31:0] result_bits;
	logic [1:0]  status;
	int          fail_count;
	int          pending;

	// Free-running 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	float_calculator_alu u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result_bits(result_bits), .status(status)
	);

	float_calculator_alu_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result_bits(result_bits), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	// Operand mix: raw bits, values near one, specials and subnormals.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6, 7: return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
			8: case ($urandom_range(0, 8))
				0: return FP_ZERO;
				1: return 32'h8000_0000;
				2: return 32'h7F80_0000;
				3: return 32'hFF80_0000;
				4: return 32'h7FC0_0000;
				5: return {1'($urandom), 8'hFF, 1'b0, 22'($urandom) | 22'h1};
				6: return FP_ONE;
				7: return 32'h007F_FFFF;
				default: return 32'h7F7F_FFFF;
			endcase
			default: return {1'($urandom), 8'h00, 23'($urandom)};
		endcase
	endfunction

	// Present one command word and hold it until the block takes it.
	// busy only moves at rising edges, so it is settled at the falling edge:
	// once it reads low there, the next rising edge takes the word.
	task automatic send_word(input logic [15:0] act, input logic [31:0] a, input logic [31:0] b,
		input bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 28) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		action = act;
		operand_a = a;
		operand_b = b;
		start = 1'b1;
		while (busy)
			@(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] act;
		logic [31:0] a, b;
		int waited;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, every operation and the special cases.
		send_word(ACT_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);   // overflow to inf
		send_word(ACT_ADD, 32'h7F80_0000, 32'hFF80_0000, 1'b0);   // inf minus inf
		send_word(ACT_SUB, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);   // NaN operand
		send_word(ACT_SUB, 32'h0000_0001, 32'h8000_0001, 1'b0);   // subnormals
		send_word(ACT_MUL, 32'h0000_0000, 32'hFF80_0000, 1'b1);   // zero times inf
		send_word(ACT_MUL, 32'h3FC0_0000, 32'hC020_0000, 1'b0);
		send_word(ACT_DIV, 32'h3F80_0000, 32'h8000_0000, 1'b1);   // divide by -0
		send_word(ACT_DIV, 32'h0000_0000, 32'h0000_0000, 1'b0);   // zero by zero
		send_word(ACT_DIV, 32'h7F81_2345, 32'h0000_0000, 1'b0);   // NaN by zero
		send_word(ACT_DIV, 32'h4049_0FDB, 32'h402D_F854, 1'b1);
		send_word(ACT_RECIP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		send_word(ACT_RECIP, 32'hC040_0000, 32'h0000_0000, 1'b1);
		send_word(ACT_SQRT, 32'h4080_0000, 32'h0000_0000, 1'b0);
		send_word(ACT_SQRT, 32'hBF80_0000, 32'h0000_0000, 1'b1);  // negative
		send_word(ACT_SQRT, 32'h8000_0000, 32'h0000_0000, 1'b0);  // minus zero
		send_word(ACT_SQRT, 32'hFFC0_0001, 32'h0000_0000, 1'b0);  // NaN runs through
		send_word(ACT_SQRT, 32'h7F80_0000, 32'h0000_0000, 1'b1);  // inf
		send_word(ACT_POW, 32'h4040_0000, 32'hC06C_CCCD, 1'b0);   // 3 ^ trunc(-3.7)
		send_word(ACT_POW, 32'hC0A0_0000, 32'h3F00_0000, 1'b1);   // n = 0
		send_word(ACT_POW, 32'h4000_0000, 32'hFF80_0000, 1'b0);   // -inf exponent saturates
		send_word(ACT_POW, 32'h0000_0000, 32'h7FC0_0000, 1'b0);   // NaN exponent
		send_word(ACT_POW, 32'h4000_0000, 32'h5015_02F9, 1'b1);   // 1e10 saturates
		send_word(16'd7, 32'h3F80_0000, 32'h3F80_0000, 1'b0);     // unknown opcode
		send_word(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

		// Random commands; keep power exponents short unless the base hits a
		// fixed point quickly. Items 300 to 449 run without gaps.
		for (int i = 0; i < 900; i++) begin
			if ($urandom_range(0, 99) < 8)
				act = 16'($urandom_range(7, 65535));
			else
				act = 16'($urandom_range(0, 6));
			a = pick_operand();
			b = pick_operand();
			if (act == ACT_POW) begin
				if ($urandom_range(0, 19) == 0) begin
					b = $urandom;
					a = {1'b0, ($urandom_range(0, 1) ? 8'($urandom_range(0, 125))
						: 8'($urandom_range(128, 255))), 23'($urandom)};
				end else
					b = {1'($urandom), 8'($urandom_range(100, 130)), 23'($urandom)};
			end
			send_word(act, a, b, !(i >= 300 && i < 450));
		end
		start = 1'b0;

		// Drain outstanding words, then give the block a little more time.
		waited = 0;
		while (pending != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end

endmodule
